FILE: hdl/ssrs_pkg.sv
package ssrs_pkg;

  localparam logic [7:0] BYTE_OVERRUN = 8'd55;
  localparam logic [7:0] BYTE_EMPTY   = 8'd41;
  localparam logic [7:0] BYTE_BUSY    = 8'd69;
  localparam logic [7:0] BYTE_ALT     = 8'd70;
  localparam logic [4:0] BUSY_LEN     = 5'd20;
  localparam logic [4:0] PHASE_END    = 5'd30;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       overrun;
    logic       rx_full;
    logic [7:0] app_answer;
  } rx_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       answer_taken;
    logic       done_res;
  } reply_t;

endpackage

FILE: hdl/spi_slave_reply_sequencer.sv
// SPI slave reply sequencer.
// Input channel (in_valid / in_stall): one beat per SPI receive event with
// rx_byte, overrun, rx_full and app_answer. Output channel (out_valid /
// out_stall): one beat per input beat with tx_byte, answer_taken and
// done_res, in input order.
// Configuration: poll_code is written via cfg_wr_en / cfg_wr_data; the user
// must write it only while the block is idle; the block does not enforce it.
// An accepted beat lands in the input register, is decoded against the
// sequencer state and is registered in the result register. Throughput: one
// beat per cycle while out_stall is low; the decode and next-state logic
// between the input and result registers are combinational.
// Stall: out_stall holds the result register; in_stall rises once the input
// register is also full, and no beat is lost or repeated.
// Reset (rst, synchronous): both registers empty, poll_code, last request,
// held response, fulfilled flag and phase count all zero.
module spi_slave_reply_sequencer
  import ssrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       overrun,
  input  logic       rx_full,
  input  logic [7:0] app_answer,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] tx_byte,
  output logic       answer_taken,
  output logic       done_res
);

  logic [7:0] poll_code;
  rx_item_t   in_item;
  rx_item_t   item;
  logic       item_valid;
  logic       advance;
  reply_t     reply;
  reply_t     out_reply;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_code <= '0;
    end else if (cfg_wr_en) begin
      poll_code <= cfg_wr_data;
    end
  end

  assign in_item.rx_byte    = rx_byte;
  assign in_item.overrun    = overrun;
  assign in_item.rx_full    = rx_full;
  assign in_item.app_answer = app_answer;

  ssrs_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  ssrs_reply_core u_reply_core (
    .clk       (clk),
    .rst       (rst),
    .poll_code (poll_code),
    .item      (item),
    .fire      (item_valid && advance),
    .reply     (reply)
  );

  ssrs_out_stage u_out_stage (
    .clk        (clk),
    .rst        (rst),
    .load_valid (item_valid),
    .load_reply (reply),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_reply  (out_reply)
  );

  assign tx_byte      = out_reply.tx_byte;
  assign answer_taken = out_reply.answer_taken;
  assign done_res     = out_reply.done_res;

endmodule

FILE: hdl/ssrs_in_stage.sv
module ssrs_in_stage
  import ssrs_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  rx_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output rx_item_t item
);

  logic load;

  // Take a new beat when the register is empty or its item moves on.
  assign load     = !item_valid || advance;
  assign in_stall = !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item <= in_item;
    end
  end

endmodule

FILE: hdl/ssrs_reply_core.sv
module ssrs_reply_core
  import ssrs_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] poll_code,
  input  rx_item_t   item,
  input  logic       fire,
  output reply_t     reply
);

  logic [7:0] last_request, last_request_next;
  logic [7:0] held_response, held_response_next;
  logic       fulfilled, fulfilled_next;
  logic [4:0] phase_count, phase_count_next;
  logic [7:0] resp_inc;

  assign resp_inc = held_response + 8'd1;

  always_comb begin
    last_request_next  = last_request;
    held_response_next = held_response;
    fulfilled_next     = fulfilled;
    phase_count_next   = phase_count;
    reply.tx_byte      = BYTE_BUSY;
    reply.answer_taken = 1'b0;

    if (item.overrun) begin
      reply.tx_byte = BYTE_OVERRUN;
    end else if (!item.rx_full) begin
      reply.tx_byte = BYTE_EMPTY;
    end else if (item.rx_byte == poll_code) begin
      if (phase_count < BUSY_LEN) begin
        reply.tx_byte    = BYTE_BUSY;
        phase_count_next = phase_count + 5'd1;
      end else if (phase_count < PHASE_END) begin
        // Never send the busy byte as data: swap in the alternate.
        reply.tx_byte    = (resp_inc == BYTE_BUSY) ? BYTE_ALT : resp_inc;
        phase_count_next = phase_count + 5'd1;
      end else begin
        reply.tx_byte  = held_response;
        fulfilled_next = 1'b1;
      end
    end else if (item.rx_byte == last_request && !fulfilled) begin
      // Repeat of an open request: restart the phase.
      phase_count_next = '0;
    end else begin
      last_request_next  = item.rx_byte;
      held_response_next = item.app_answer;
      fulfilled_next     = 1'b0;
      phase_count_next   = '0;
      reply.answer_taken = 1'b1;
    end

    reply.done_res = fulfilled_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_request  <= '0;
      held_response <= '0;
      fulfilled     <= 1'b0;
      phase_count   <= '0;
    end else if (fire) begin
      last_request  <= last_request_next;
      held_response <= held_response_next;
      fulfilled     <= fulfilled_next;
      phase_count   <= phase_count_next;
    end
  end

endmodule

FILE: hdl/ssrs_out_stage.sv
module ssrs_out_stage
  import ssrs_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   load_valid,
  input  reply_t load_reply,
  output logic   advance,
  output logic   out_valid,
  input  logic   out_stall,
  output reply_t out_reply
);

  // Hold the result while the receiver stalls; otherwise refill.
  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && load_valid) begin
      out_reply <= load_reply;
    end
  end

endmodule

FILE: hdl/ssrs_checker.sv
module ssrs_checker
  import ssrs_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] tx_byte,
  input logic       answer_taken,
  input logic       done_res
);

  // Hold a stalled result beat.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(answer_taken)
      && $stable(done_res))
    else $error("stalled output beat changed");

  // A new request always replies busy and clears the fulfilled flag.
  a_new_request: assert property (@(posedge clk) disable iff (rst)
    out_valid && answer_taken |-> tx_byte == BYTE_BUSY && !done_res)
    else $error("new request reply malformed");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A beat offered to an empty, unstalled pipeline is taken at once.
  a_no_spurious_stall: assert property (@(posedge clk) disable iff (rst)
    !out_valid && $past(!out_valid) && !$past(in_valid && !in_stall) && !$past(rst)
      |-> !in_stall)
    else $error("input stalled while pipeline empty");

endmodule

bind spi_slave_reply_sequencer ssrs_checker u_ssrs_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .tx_byte      (tx_byte),
  .answer_taken (answer_taken),
  .done_res     (done_res)
);
